// ----- hdl/grouped_bitmap_block_allocator_macros.svh -----
// Assertion macros used by the allocator source.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define GBBA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gbba assertion failed");
// Check that cons holds in the cycle after ante.
`define GBBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gbba assertion failed");
`else
`define GBBA_ASSERT(name, prop)
`define GBBA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ----- hdl/gbba_pkg.sv -----
package gbba_pkg;

  // Field and register widths
  localparam int GS_W       = 14;
  localparam int BT_W       = 17;
  localparam int IDX_W      = 16;
  localparam int STS_W      = 2;
  localparam int CNT_W      = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam int GS_MIN = 8;
  localparam logic [CNT_W-1:0] GCNT_MAX = '1;

  localparam logic [GS_W-1:0] GROUP_SIZE_RST  = 14'd8192;
  localparam logic [BT_W-1:0] BLOCK_TOTAL_RST = 17'd65536;

  // Parameter defaults
  localparam int unsigned MAX_BLOCKS_DEF  = 65536;
  localparam int unsigned BLOCK_BYTES_DEF = 1024;
  localparam int unsigned MAX_GROUPS_DEF  = 64;
  localparam int unsigned WORD_BITS_DEF   = 32;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_MARK  = 1'b1
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_RANGE   = 2'd2,
    STS_USED    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUP_SIZE  = 1'b0,
    REG_BLOCK_TOTAL = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_CHK,
    S_DIV,
    S_MARK_GRP,
    S_MARK_WR,
    S_ALLOC_CHK,
    S_ALLOC_GRP,
    S_ALLOC_GCHK,
    S_ALLOC_WORD,
    S_RESP
  } state_e;

  function automatic int max_w(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- hdl/gbba_req_if.sv -----
interface gbba_req_if;
  import gbba_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output command, output block_index, input ready);
  modport sink (input valid, input command, input block_index, output ready);
endinterface

// ----- hdl/gbba_rsp_if.sv -----
interface gbba_rsp_if;
  import gbba_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] block_number;
  logic [STS_W-1:0] status;

  modport source (output valid, output block_number, output status, input ready);
  modport sink (input valid, input block_number, input status, output ready);
endinterface

// ----- hdl/gbba_div.sv -----
// Restoring divider, one quotient bit per cycle, MSB first.
// The quotient must fit in QW bits.
module gbba_div #(
  parameter int NW = 16,
  parameter int DW = 14,
  parameter int QW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quotient_o
);
  import gbba_pkg::*;

  localparam int CW = max_w(NW, DW + QW);
  localparam int SW = (QW > 1) ? $clog2(QW) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dv_q, dv_d;
  logic [QW-1:0] quo_q, quo_d;

  always_comb begin
    logic fit;
    fit    = (rem_q >= dv_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = SW'(QW - 1);
      rem_d  = CW'(dividend_i);
      dv_d   = CW'(divisor_i) << (QW - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (fit) begin
        rem_d = rem_q - dv_q;
      end
      quo_d = (quo_q << 1) | QW'(fit);
      dv_d  = dv_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hdl/grouped_bitmap_block_allocator.sv -----
// First-fit block allocator over a used-bit map split into groups. The map lives in a
// single-port-style synchronous RAM of MAX_BLOCKS/WORD_BITS words; per-group used counts
// live in a small RAM with one valid flop per entry; a total used count sits in a register.
// After reset the map RAM is swept clear, one word a cycle, over all MAX_BLOCKS/WORD_BITS
// words (2048 at the defaults); no item is accepted during the sweep, configuration writes are.
// One item is processed at a time. A mark request finds its group with the bit-serial
// group divider. An allocate request checks the free count, then fetches and checks the
// count of each group visited, and scans the map words of each group counted not full,
// so the scan is bounded by the map read port: one word per cycle. A request that fails
// the free-count check goes straight to the response. The result is held in an output
// register, so the next item is accepted while the last result waits to be taken.
// Configuration (group_size, block_total) must only be written while the block is idle.
module grouped_bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS  = gbba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = gbba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAX_GROUPS  = gbba_pkg::MAX_GROUPS_DEF,
  parameter int unsigned WORD_BITS   = gbba_pkg::WORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gbba_req_if.sink                        req_i,
  gbba_rsp_if.source                      rsp_o
);
  import gbba_pkg::*;

  `include "grouped_bitmap_block_allocator_macros.svh"

  // WORD_BITS is a power of two
  localparam int WB        = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int GRP_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int TOT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int LIM_W     = GS_W + $clog2(MAX_GROUPS + 1);
  localparam int CMP_W     = max_w(max_w(BT_W, LIM_W), TOT_W);
  localparam int SUM_W     = max_w(TOT_W, GS_W) + 1;
  localparam int GS_HI     = (8 * BLOCK_BYTES < 2 ** GS_W - 1) ? 8 * BLOCK_BYTES
                                                               : 2 ** GS_W - 1;

  // Configuration registers
  logic [GS_W-1:0] group_size_q;
  logic [BT_W-1:0] block_total_q;

  // Control state
  state_e          state_q, state_d;
  logic [WA_W-1:0] clr_q, clr_d;
  logic [TOT_W-1:0] total_used_q, total_used_d;
  logic            out_vld_q, out_vld_d;
  logic [MAX_GROUPS-1:0] grp_vld_q;

  // Item context
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [GS_W-1:0]  gs_q, gs_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [GRP_W-1:0] g_q, g_d;
  logic [TOT_W-1:0] base_q, base_d;
  logic [GS_W-1:0]  len_q, len_d;
  logic [WA_W-1:0]  w_q, w_d;
  logic [WA_W-1:0]  last_w_q, last_w_d;
  logic [WB-1:0]    base_off_q, base_off_d;
  logic [WB-1:0]    last_off_q, last_off_d;
  logic             first_q, first_d;
  logic [IDX_W-1:0] res_blk_q, res_blk_d;
  status_e          res_sts_q, res_sts_d;
  logic [IDX_W-1:0] out_blk_q, out_blk_d;
  status_e          out_sts_q, out_sts_d;

  // Memories
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] map_rdata_q;
  logic                 map_re, map_we;
  logic [WA_W-1:0]      map_raddr, map_waddr;
  logic [WORD_BITS-1:0] map_wdata;

  logic [CNT_W-1:0] grp_mem [MAX_GROUPS];
  logic [CNT_W-1:0] grp_rdata_q;
  logic             grp_rvld_q;
  logic             grp_re, grp_we;
  logic [CNT_W-1:0] grp_wdata;

  // Datapath helpers
  logic [GS_W-1:0]      gs_eff;
  logic [TOT_W-1:0]     total_eff;
  logic                 in_range;
  logic [CNT_W-1:0]     grp_cnt;
  logic                 grp_full;
  logic [SUM_W-1:0]     next_base;
  logic                 no_more_grp;
  logic [WORD_BITS-1:0] word_mask;
  logic [WORD_BITS-1:0] word_free;
  logic [WB-1:0]        ffs_pos;
  logic                 word_hit;
  logic [WB-1:0]        take_pos;
  logic                 mark_bit_set;
  logic                 out_free;
  logic                 accept;
  logic                 div_start, div_done;
  logic [GRP_W-1:0]     div_quo;

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q  <= GROUP_SIZE_RST;
      block_total_q <= BLOCK_TOTAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GROUP_SIZE:  group_size_q  <= cfg_data_i[GS_W-1:0];
        REG_BLOCK_TOTAL: block_total_q <= cfg_data_i[BT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective group size and managed total, sampled when an item is accepted
  always_comb begin
    logic [LIM_W-1:0] lim;
    logic [CMP_W-1:0] tot;
    if (group_size_q < GS_W'(GS_MIN)) begin
      gs_eff = GS_W'(GS_MIN);
    end else if (group_size_q > GS_W'(GS_HI)) begin
      gs_eff = GS_W'(GS_HI);
    end else begin
      gs_eff = group_size_q;
    end
    lim = LIM_W'(MAX_GROUPS) * LIM_W'(gs_eff);
    tot = CMP_W'(block_total_q);
    if (tot > CMP_W'(MAX_BLOCKS)) begin
      tot = CMP_W'(MAX_BLOCKS);
    end
    if (tot > CMP_W'(lim)) begin
      tot = CMP_W'(lim);
    end
    total_eff = TOT_W'(tot);
  end

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign in_range = CMP_W'(idx_q) < CMP_W'(total_q);

  // Group count as read; an entry never written reads as zero
  assign grp_cnt  = grp_rvld_q ? grp_rdata_q : '0;
  assign grp_full = (grp_cnt >= len_q);

  // Start of the following group; none left once it reaches the managed total
  assign next_base   = SUM_W'(base_q) + SUM_W'(gs_q);
  assign no_more_grp = (next_base >= SUM_W'(total_q));

  // Free bits of the current word inside the group's span, lowest one first
  always_comb begin
    logic [WB-1:0] lo_off;
    logic [WB-1:0] hi_off;
    lo_off = first_q ? base_off_q : '0;
    hi_off = (w_q == last_w_q) ? last_off_q : '1;
    for (int i = 0; i < WORD_BITS; i++) begin
      word_mask[i] = (WB'(i) >= lo_off) && (WB'(i) <= hi_off);
    end
  end

  assign word_free = ~map_rdata_q & word_mask;
  assign word_hit  = |word_free;

  always_comb begin
    ffs_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_free[i]) begin
        ffs_pos = WB'(i);
      end
    end
  end

  assign mark_bit_set = map_rdata_q[idx_q[WB-1:0]];
  assign take_pos     = (state_q == S_MARK_WR) ? idx_q[WB-1:0] : ffs_pos;

  // Group number of a block to mark
  assign div_start = (state_q == S_MARK_CHK) && in_range;

  gbba_div #(
    .NW (IDX_W),
    .DW (GS_W),
    .QW (GRP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (idx_q),
    .divisor_i  (gs_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == WA_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (req_i.command == CMD_MARK) ? S_MARK_CHK : S_ALLOC_CHK;
        end
      end
      S_MARK_CHK:  state_d = in_range ? S_DIV : S_RESP;
      S_DIV: begin
        if (div_done) begin
          state_d = S_MARK_GRP;
        end
      end
      S_MARK_GRP:  state_d = mark_bit_set ? S_RESP : S_MARK_WR;
      S_MARK_WR:   state_d = S_RESP;
      S_ALLOC_CHK: state_d = (total_used_q >= total_q) ? S_RESP : S_ALLOC_GRP;
      S_ALLOC_GRP: state_d = S_ALLOC_GCHK;
      S_ALLOC_GCHK: begin
        if (!grp_full) begin
          state_d = S_ALLOC_WORD;
        end else if (no_more_grp) begin
          state_d = S_RESP;
        end else begin
          state_d = S_ALLOC_GRP;
        end
      end
      S_ALLOC_WORD: begin
        if (word_hit) begin
          state_d = S_RESP;
        end else if (w_q == last_w_q) begin
          state_d = no_more_grp ? S_RESP : S_ALLOC_GRP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    logic [TOT_W-1:0] rest;
    logic [GS_W-1:0]  len_v;
    logic [TOT_W-1:0] last_v;

    clr_d        = clr_q;
    total_used_d = total_used_q;
    out_vld_d    = out_vld_q;
    out_blk_d    = out_blk_q;
    out_sts_d    = out_sts_q;
    idx_d        = idx_q;
    gs_d         = gs_q;
    total_d      = total_q;
    g_d          = g_q;
    base_d       = base_q;
    len_d        = len_q;
    w_d          = w_q;
    last_w_d     = last_w_q;
    base_off_d   = base_off_q;
    last_off_d   = last_off_q;
    first_d      = first_q;
    res_blk_d    = res_blk_q;
    res_sts_d    = res_sts_q;

    map_re    = 1'b0;
    map_raddr = w_q;
    map_we    = 1'b0;
    map_waddr = w_q;
    map_wdata = map_rdata_q | (WORD_BITS'(1) << take_pos);
    grp_re    = 1'b0;
    grp_we    = 1'b0;
    grp_wdata = (grp_cnt == GCNT_MAX) ? grp_cnt : grp_cnt + 1'b1;

    rest   = total_q - base_q;
    len_v  = (SUM_W'(rest) > SUM_W'(gs_q)) ? gs_q : GS_W'(rest);
    last_v = base_q + TOT_W'(len_v) - 1'b1;

    // Drop the output item once taken
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          idx_d   = req_i.block_index;
          gs_d    = gs_eff;
          total_d = total_eff;
        end
      end
      S_MARK_CHK: begin
        if (in_range) begin
          map_re    = 1'b1;
          map_raddr = WA_W'(idx_q >> WB);
          w_d       = WA_W'(idx_q >> WB);
        end else begin
          res_blk_d = '0;
          res_sts_d = STS_RANGE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          g_d = div_quo;
        end
      end
      S_MARK_GRP: begin
        if (mark_bit_set) begin
          res_blk_d = '0;
          res_sts_d = STS_USED;
        end else begin
          grp_re = 1'b1;
        end
      end
      S_MARK_WR: begin
        map_we       = 1'b1;
        grp_we       = 1'b1;
        total_used_d = total_used_q + 1'b1;
        res_blk_d    = idx_q;
        res_sts_d    = STS_OK;
      end
      S_ALLOC_CHK: begin
        g_d       = '0;
        base_d    = '0;
        res_blk_d = '0;
        res_sts_d = STS_NO_FREE;
      end
      S_ALLOC_GRP: begin
        // Fetch the group count and set up the group's word span
        grp_re     = 1'b1;
        len_d      = len_v;
        w_d        = WA_W'(base_q >> WB);
        last_w_d   = WA_W'(last_v >> WB);
        base_off_d = base_q[WB-1:0];
        last_off_d = last_v[WB-1:0];
      end
      S_ALLOC_GCHK: begin
        if (!grp_full) begin
          map_re  = 1'b1;
          first_d = 1'b1;
        end else if (!no_more_grp) begin
          g_d    = g_q + 1'b1;
          base_d = TOT_W'(next_base);
        end
      end
      S_ALLOC_WORD: begin
        if (word_hit) begin
          map_we       = 1'b1;
          grp_we       = 1'b1;
          total_used_d = total_used_q + 1'b1;
          res_blk_d    = IDX_W'({w_q, ffs_pos});
          res_sts_d    = STS_OK;
        end else if (w_q == last_w_q) begin
          // Group yields nothing: advance to the next one
          if (!no_more_grp) begin
            g_d    = g_q + 1'b1;
            base_d = TOT_W'(next_base);
          end
        end else begin
          map_re    = 1'b1;
          map_raddr = w_q + 1'b1;
          w_d       = w_q + 1'b1;
          first_d   = 1'b0;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_blk_d = res_blk_q;
          out_sts_d = res_sts_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      total_used_q <= '0;
      out_vld_q    <= 1'b0;
      grp_vld_q    <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      total_used_q <= total_used_d;
      out_vld_q    <= out_vld_d;
      if (grp_we) begin
        grp_vld_q[g_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    gs_q       <= gs_d;
    total_q    <= total_d;
    g_q        <= g_d;
    base_q     <= base_d;
    len_q      <= len_d;
    w_q        <= w_d;
    last_w_q   <= last_w_d;
    base_off_q <= base_off_d;
    last_off_q <= last_off_d;
    first_q    <= first_d;
    res_blk_q  <= res_blk_d;
    res_sts_q  <= res_sts_d;
    out_blk_q  <= out_blk_d;
    out_sts_q  <= out_sts_d;
  end

  // Used-bit map RAM. Writes happen only in the reset sweep and at the end of an item, with
  // the S_RESP and S_IDLE states before the next item reads, so no forwarding path is needed.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_q <= map_mem[map_raddr];
    end
  end

  // Group count RAM
  always_ff @(posedge clk_i) begin
    if (grp_we) begin
      grp_mem[g_q] <= grp_wdata;
    end
    if (grp_re) begin
      grp_rdata_q <= grp_mem[g_q];
      grp_rvld_q  <= grp_vld_q[g_q];
    end
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.block_number = out_blk_q;
  assign rsp_o.status       = out_sts_q;

  `GBBA_ASSERT(a_fail_zero_blk, (rsp_o.valid && rsp_o.status != STS_OK) |-> (rsp_o.block_number == '0))
  `GBBA_ASSERT(a_map_we_state, map_we |-> (state_q == S_CLEAR || state_q == S_MARK_WR || state_q == S_ALLOC_WORD))
  `GBBA_ASSERT(a_used_step, (total_used_q != $past(total_used_q)) |-> (total_used_q == $past(total_used_q) + 1'b1))
  `GBBA_ASSERT_NEXT(a_resp_hold, state_q == S_RESP && rsp_o.valid && !rsp_o.ready, state_q == S_RESP)

endmodule
